>>> hw/rtl/kpvt_pkg.sv
// kpvt_pkg: shared types, sequencer states and microcode for the Kalman tracker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package kpvt_pkg;

  localparam int unsigned AddrW = 5;

  localparam logic [2:0] RegDt     = 3'd0;
  localparam logic [2:0] RegQPos   = 3'd1;
  localparam logic [2:0] RegQVel   = 3'd2;
  localparam logic [2:0] RegRMeas  = 3'd3;
  localparam logic [2:0] RegInitX  = 3'd4;
  localparam logic [2:0] RegInitV  = 3'd5;
  localparam logic [2:0] RegInitPx = 3'd6;
  localparam logic [2:0] RegInitPv = 3'd7;

  localparam logic [30:0] DtRst    = 31'd6554;
  localparam logic [30:0] QPosRst  = 31'd0;
  localparam logic [30:0] QVelRst  = 31'd0;
  localparam logic [30:0] RMeasRst = 31'd327680;
  localparam logic signed [31:0] InitXRst = 32'sd655360;
  localparam logic signed [31:0] InitVRst = 32'sd294912;
  localparam logic [30:0] InitPxRst = 31'd32768000;
  localparam logic [30:0] InitPvRst = 31'd3211264;

  localparam logic [3:0] StepS    = 4'd7;
  localparam logic [3:0] StepLast = 4'd13;

  typedef struct packed {
    logic [30:0] dt;
    logic [30:0] q_pos;
    logic [30:0] q_vel;
    logic [30:0] r_meas;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] base;
    logic signed [31:0] ma;
    logic signed [31:0] mb;
    logic signed [31:0] ext;
    logic               sub;
  } alu_req_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_ACC, ST_DIV_GO, ST_DIV_WAIT, ST_OUT
  } state_e;

  typedef enum logic [4:0] {
    OPD_ZERO, OPD_ONE, OPD_DT, OPD_Z, OPD_POS, OPD_VEL,
    OPD_P00, OPD_P01, OPD_P10, OPD_P11,
    OPD_XP, OPD_FP00, OPD_FP01, OPD_PP00, OPD_PP10, OPD_PP11,
    OPD_Y, OPD_S, OPD_K0, OPD_K1, OPD_QPOS, OPD_QVEL, OPD_RMEAS
  } opnd_e;

  typedef struct packed {
    opnd_e dst;
    opnd_e base;
    opnd_e ma;
    opnd_e mb;
    opnd_e ext;
    logic  sub;
  } uop_t;

  // dst = sat(base +/- mulq(ma, mb) + ext)
  function automatic uop_t uop(input logic [3:0] step);
    uop_t u;
    u = '{OPD_ZERO, OPD_ZERO, OPD_ZERO, OPD_ZERO, OPD_ZERO, 1'b0};
    case (step)
      4'd0:  u = '{OPD_XP,   OPD_POS,  OPD_DT,   OPD_VEL,  OPD_ZERO,  1'b0};
      4'd1:  u = '{OPD_FP00, OPD_P00,  OPD_DT,   OPD_P10,  OPD_ZERO,  1'b0};
      4'd2:  u = '{OPD_FP01, OPD_P01,  OPD_DT,   OPD_P11,  OPD_ZERO,  1'b0};
      4'd3:  u = '{OPD_PP00, OPD_FP00, OPD_FP01, OPD_DT,   OPD_QPOS,  1'b0};
      4'd4:  u = '{OPD_PP10, OPD_P10,  OPD_P11,  OPD_DT,   OPD_ZERO,  1'b0};
      4'd5:  u = '{OPD_PP11, OPD_P11,  OPD_ZERO, OPD_ZERO, OPD_QVEL,  1'b0};
      4'd6:  u = '{OPD_Y,    OPD_Z,    OPD_XP,   OPD_ONE,  OPD_ZERO,  1'b1};
      4'd7:  u = '{OPD_S,    OPD_PP00, OPD_ZERO, OPD_ZERO, OPD_RMEAS, 1'b0};
      4'd8:  u = '{OPD_POS,  OPD_XP,   OPD_K0,   OPD_Y,    OPD_ZERO,  1'b0};
      4'd9:  u = '{OPD_VEL,  OPD_VEL,  OPD_K1,   OPD_Y,    OPD_ZERO,  1'b0};
      4'd10: u = '{OPD_P00,  OPD_PP00, OPD_K0,   OPD_PP00, OPD_ZERO,  1'b1};
      4'd11: u = '{OPD_P01,  OPD_FP01, OPD_K0,   OPD_FP01, OPD_ZERO,  1'b1};
      4'd12: u = '{OPD_P10,  OPD_PP10, OPD_K1,   OPD_PP00, OPD_ZERO,  1'b1};
      4'd13: u = '{OPD_P11,  OPD_PP11, OPD_K1,   OPD_FP01, OPD_ZERO,  1'b1};
      default: u = '{OPD_ZERO, OPD_ZERO, OPD_ZERO, OPD_ZERO, OPD_ZERO, 1'b0};
    endcase
    return u;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/kalman_position_velocity_tracker_core.sv
// Two-state constant-velocity Kalman tracker, Q(32-FRAC_BITS).FRAC_BITS fixed point.
// Each update runs 14 multiply-accumulate steps, each a multiply state then an accumulate
// state, plus two serial divisions for the gains (skipped on a gain fault).
// One measurement at a time: a new one is taken only when the sequencer is idle.
// Reset (async, active low) loads the reset estimate and diagonal covariance constants.
`timescale 1ns / 1ps
`default_nettype none
module kalman_position_velocity_tracker_core #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // measurement channel
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic signed [31:0]        measured_pos_i,
  // estimate channel
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic signed [31:0]             est_position_o,
  output logic signed [31:0]             est_velocity_o,
  output logic signed [31:0]             pos_variance_o,
  output logic signed [31:0]             vel_variance_o,
  output logic                           gain_fault_o,
  // APB register port
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [kpvt_pkg::AddrW-1:0] paddr,
  input  wire logic [31:0]               pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import kpvt_pkg::*;

  localparam logic signed [31:0] One = 32'sd1 <<< FRAC_BITS;

  cfg_t cfg;

  // sequencer
  state_e     state_q, state_d;
  logic [3:0] step_q;
  logic       ksel_q;
  uop_t       cur;

  // decoded controls
  logic alu_load, acc_wr, div_start, k_zero, out_load, in_xfer;

  // estimate state and per-step temporaries
  logic signed [31:0] pos_q, vel_q, p00_q, p01_q, p10_q, p11_q;
  logic signed [31:0] z_q, xp_q, fp00_q, fp01_q, pp00_q, pp10_q, pp11_q;
  logic signed [31:0] y_q, s_q, k0_q, k1_q;
  logic               fault_q, s_bad;

  alu_req_t           req;
  logic signed [31:0] alu_res, div_quo;
  logic               div_done;

  assign pready = 1'b1;

  kpvt_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
    .cfg_o(cfg)
  );

  // operand selection for the shared unit
  function automatic logic signed [31:0] opnd(input opnd_e o);
    logic signed [31:0] v;
    case (o)
      OPD_ONE:   v = One;
      OPD_DT:    v = {1'b0, cfg.dt};
      OPD_Z:     v = z_q;
      OPD_POS:   v = pos_q;
      OPD_VEL:   v = vel_q;
      OPD_P00:   v = p00_q;
      OPD_P01:   v = p01_q;
      OPD_P10:   v = p10_q;
      OPD_P11:   v = p11_q;
      OPD_XP:    v = xp_q;
      OPD_FP00:  v = fp00_q;
      OPD_FP01:  v = fp01_q;
      OPD_PP00:  v = pp00_q;
      OPD_PP10:  v = pp10_q;
      OPD_PP11:  v = pp11_q;
      OPD_Y:     v = y_q;
      OPD_S:     v = s_q;
      OPD_K0:    v = k0_q;
      OPD_K1:    v = k1_q;
      OPD_QPOS:  v = {1'b0, cfg.q_pos};
      OPD_QVEL:  v = {1'b0, cfg.q_vel};
      OPD_RMEAS: v = {1'b0, cfg.r_meas};
      default:   v = '0;
    endcase
    return v;
  endfunction

  // re-evaluated whenever any selectable register changes, gains included
  always_comb begin
    cur = uop(step_q);
    req = '{base: opnd(cur.base), ma: opnd(cur.ma), mb: opnd(cur.mb),
            ext: opnd(cur.ext), sub: cur.sub};
  end

  kpvt_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
    .clk_i, .load_i(alu_load), .req_i(req), .res_o(alu_res)
  );

  // gain numerator is predicted P00 for the position gain, predicted P10 for velocity
  kpvt_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i, .rst_ni, .start_i(div_start),
    .num_i(ksel_q ? pp10_q : pp00_q), .den_i(s_q[30:0]),
    .done_o(div_done), .quo_o(div_quo)
  );

  // innovation variance not positive -> gains forced to zero
  assign s_bad = s_q[31] || (s_q == '0);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (in_valid_i) state_d = ST_MUL;
      ST_MUL:      state_d = ST_ACC;
      ST_ACC: begin
        if (step_q == StepLast)   state_d = ST_OUT;
        else if (step_q == StepS) state_d = ST_DIV_GO;
        else                      state_d = ST_MUL;
      end
      ST_DIV_GO:   state_d = s_bad ? ST_MUL : ST_DIV_WAIT;
      ST_DIV_WAIT: if (div_done) state_d = ksel_q ? ST_MUL : ST_DIV_GO;
      ST_OUT:      if (!out_valid_o || out_ready_i) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready_o = 1'b0;
    alu_load   = 1'b0;
    acc_wr     = 1'b0;
    div_start  = 1'b0;
    k_zero     = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE:   in_ready_o = 1'b1;
      ST_MUL:    alu_load   = 1'b1;
      ST_ACC:    acc_wr     = 1'b1;
      ST_DIV_GO: begin
        k_zero    = s_bad;
        div_start = !s_bad;
      end
      ST_OUT:    out_load = !out_valid_o || out_ready_i;
      default: ;
    endcase
  end

  assign in_xfer = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      ksel_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_xfer) begin
        step_q <= '0;
        ksel_q <= 1'b0;
      end else if (acc_wr) begin
        step_q <= step_q + 1'b1;
      end
      if (state_q == ST_DIV_WAIT && div_done) ksel_q <= 1'b1;
    end
  end

  // estimate and covariance, written back by the last six steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= InitXRst;
      vel_q <= InitVRst;
      p00_q <= {1'b0, InitPxRst};
      p01_q <= '0;
      p10_q <= '0;
      p11_q <= {1'b0, InitPvRst};
    end else if (acc_wr) begin
      case (cur.dst)
        OPD_POS: pos_q <= alu_res;
        OPD_VEL: vel_q <= alu_res;
        OPD_P00: p00_q <= alu_res;
        OPD_P01: p01_q <= alu_res;
        OPD_P10: p10_q <= alu_res;
        OPD_P11: p11_q <= alu_res;
        default: ;
      endcase
    end
  end

  // temporaries of one step
  always_ff @(posedge clk_i) begin
    if (in_xfer) z_q <= measured_pos_i;
    if (acc_wr) begin
      case (cur.dst)
        OPD_XP:   xp_q   <= alu_res;
        OPD_FP00: fp00_q <= alu_res;
        OPD_FP01: fp01_q <= alu_res;
        OPD_PP00: pp00_q <= alu_res;
        OPD_PP10: pp10_q <= alu_res;
        OPD_PP11: pp11_q <= alu_res;
        OPD_Y:    y_q    <= alu_res;
        OPD_S:    s_q    <= alu_res;
        default: ;
      endcase
    end
    if (k_zero) begin
      k0_q <= '0;
      k1_q <= '0;
    end else if (state_q == ST_DIV_WAIT && div_done) begin
      if (ksel_q) k1_q <= div_quo;
      else        k0_q <= div_quo;
    end
    if (state_q == ST_DIV_GO) fault_q <= s_bad;
  end

  // result register: frees the sequencer to take the next measurement
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      est_position_o <= pos_q;
      est_velocity_o <= vel_q;
      pos_variance_o <= p00_q;
      vel_variance_o <= p11_q;
      gain_fault_o   <= fault_q;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/kpvt_cfg.sv
// kpvt_cfg: APB register bank for the tracker settings.
// Depends on kpvt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module kpvt_cfg (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [kpvt_pkg::AddrW-1:0] paddr,
  input  wire logic [31:0]               pwdata,
  output logic [31:0]                    prdata,
  output kpvt_pkg::cfg_t                 cfg_o
);
  import kpvt_pkg::*;

  logic [30:0] dt_q, qp_q, qv_q, rm_q, ipx_q, ipv_q;
  logic [31:0] ix_q, iv_q;
  logic        wr;
  logic [2:0]  idx;

  assign wr  = psel & penable & pwrite;
  assign idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q  <= DtRst;
      qp_q  <= QPosRst;
      qv_q  <= QVelRst;
      rm_q  <= RMeasRst;
      ix_q  <= InitXRst;
      iv_q  <= InitVRst;
      ipx_q <= InitPxRst;
      ipv_q <= InitPvRst;
    end else if (wr) begin
      case (idx)
        RegDt:     dt_q  <= pwdata[30:0];
        RegQPos:   qp_q  <= pwdata[30:0];
        RegQVel:   qv_q  <= pwdata[30:0];
        RegRMeas:  rm_q  <= pwdata[30:0];
        RegInitX:  ix_q  <= pwdata;
        RegInitV:  iv_q  <= pwdata;
        RegInitPx: ipx_q <= pwdata[30:0];
        RegInitPv: ipv_q <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegDt:     prdata = {1'b0, dt_q};
      RegQPos:   prdata = {1'b0, qp_q};
      RegQVel:   prdata = {1'b0, qv_q};
      RegRMeas:  prdata = {1'b0, rm_q};
      RegInitX:  prdata = ix_q;
      RegInitV:  prdata = iv_q;
      RegInitPx: prdata = {1'b0, ipx_q};
      RegInitPv: prdata = {1'b0, ipv_q};
      default:   prdata = '0;
    endcase
  end

  assign cfg_o = '{dt: dt_q, q_pos: qp_q, q_vel: qv_q, r_meas: rm_q};

endmodule
`default_nettype wire

>>> hw/rtl/kpvt_alu.sv
// kpvt_alu: shared multiply-accumulate unit, sat(base +/- round(ma*mb) + ext).
// Depends on kpvt_pkg. Load cycle registers the product; result is valid next cycle.
`timescale 1ns / 1ps
`default_nettype none
module kpvt_alu #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               load_i,
  input  wire kpvt_pkg::alu_req_t req_i,
  output logic signed [31:0]      res_o
);
  import kpvt_pkg::*;

  localparam logic signed [63:0] Half = 64'sd1 <<< (FRAC_BITS - 1);

  logic signed [63:0] prod_q;
  logic signed [31:0] base_q, ext_q;
  logic               sub_q;
  logic signed [63:0] m, sum;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= 64'($signed(req_i.ma)) * 64'($signed(req_i.mb));
      base_q <= req_i.base;
      ext_q  <= req_i.ext;
      sub_q  <= req_i.sub;
    end
  end

  always_comb begin
    m   = (prod_q + Half) >>> FRAC_BITS;  // round half up
    sum = 64'(base_q) + (sub_q ? -m : m) + 64'(ext_q);
    if (sum > 64'sd2147483647)       res_o = 32'sh7fffffff;
    else if (sum < -64'sd2147483648) res_o = 32'sh80000000;
    else                             res_o = sum[31:0];
  end

endmodule
`default_nettype wire

>>> hw/rtl/kpvt_div.sv
// kpvt_div: radix-2 restoring divider, sat((num << FRAC_BITS) / den), toward zero.
// Depends on kpvt_pkg. Produces 32+FRAC_BITS quotient bits serially; den must be positive.
`timescale 1ns / 1ps
`default_nettype none
module kpvt_div #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [31:0] num_i,
  input  wire logic [30:0]        den_i,
  output logic                    done_o,
  output logic signed [31:0]      quo_o
);
  import kpvt_pkg::*;

  localparam int unsigned NW = 32 + FRAC_BITS;
  localparam int unsigned CW = $clog2(NW + 1);

  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q, neg_q;
  logic [NW-1:0] dvd_q, quo_q;
  logic [30:0]   rem_q, den_q;
  logic [31:0]   trial, mag;
  logic          qbit;

  assign mag   = num_i[31] ? 32'(-num_i) : num_i;
  assign trial = {rem_q, dvd_q[NW-1]};
  assign qbit  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= {mag, {FRAC_BITS{1'b0}}};
      quo_q <= '0;
      rem_q <= '0;
      den_q <= den_i;
      neg_q <= num_i[31];
    end else if (busy_q) begin
      dvd_q <= {dvd_q[NW-2:0], 1'b0};
      quo_q <= {quo_q[NW-2:0], qbit};
      rem_q <= qbit ? 31'(trial - {1'b0, den_q}) : trial[30:0];
    end
  end

  always_comb begin
    if (!neg_q) begin
      quo_o = (|quo_q[NW-1:31]) ? 32'sh7fffffff : {1'b0, quo_q[30:0]};
    end else if ((|quo_q[NW-1:32]) || (quo_q[31] && (|quo_q[30:0]))) begin
      quo_o = 32'sh80000000;
    end else begin
      quo_o = 32'(-quo_q[31:0]);
    end
  end

  assign done_o = done_q;

endmodule
`default_nettype wire
